// ===== rtl/core/lthb_pkg.sv =====
// ----------------------------------------------------------------------------
// lthb_pkg
// Shared widths, types, register indexes and helpers for the lookahead
// threshold bundler.
// ----------------------------------------------------------------------------
package lthb_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int DATA_W       = 16;
    localparam int HANG_W       = 7;
    localparam int MODE_W       = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int IDX_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int NCMP_W       = (CNT_W > HANG_W) ? CNT_W : HANG_W;

    typedef logic signed [DATA_W-1:0] q88_t;
    typedef logic [CNT_W-1:0]         count_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [HANG_W-1:0]        hang_t;
    typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

    localparam count_t DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
    localparam idx_t   LAST_IDX  = IDX_W'(WINDOW_DEPTH - 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_EXTREMUM  = 2'd0,
        MODE_PREVIOUS  = 2'd1,
        MODE_THRESHOLD = 2'd2,
        MODE_SET       = 2'd3
    } replace_mode_t;

    localparam cfg_idx_t REG_THRESHOLD    = 3'd0;
    localparam cfg_idx_t REG_HANG_IN      = 3'd1;
    localparam cfg_idx_t REG_HANG_OUT     = 3'd2;
    localparam cfg_idx_t REG_REPLACE_ABV  = 3'd3;
    localparam cfg_idx_t REG_REPLACE_BLW  = 3'd4;
    localparam cfg_idx_t REG_SET_ABOVE    = 3'd5;
    localparam cfg_idx_t REG_SET_BELOW    = 3'd6;
    localparam cfg_idx_t REG_BINARIZE     = 3'd7;

    // Summary of the lookahead span as seen by the row of cells.
    typedef struct packed {
        logic all_above;
        logic none_above;
    } window_status_t;

    // A hang count beyond the window is limited to the window length.
    function automatic count_t clamp_hang(input hang_t h);
        count_t r;
        if (NCMP_W'(h) > NCMP_W'(WINDOW_DEPTH))
            r = DEPTH_CNT;
        else
            r = CNT_W'(h);
        return r;
    endfunction

endpackage

// ===== rtl/core/lthb_channels.sv =====
// ----------------------------------------------------------------------------
// lthb_channels
// Valid/ready channel interfaces for samples and bundled results.
// ----------------------------------------------------------------------------
interface lthb_sample_if;
    import lthb_pkg::*;

    logic valid;
    logic ready;
    q88_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface lthb_result_if;
    import lthb_pkg::*;

    logic valid;
    logic ready;
    q88_t out_value;
    logic side_above;

    modport source (output valid, output out_value, output side_above, input ready);
    modport sink   (input valid, input out_value, input side_above, output ready);
endinterface

// ===== rtl/core/lookahead_threshold_bundler_top.sv =====
// ----------------------------------------------------------------------------
// lookahead_threshold_bundler_top
// Single-channel lookahead threshold bundler on signed Q8.8 samples.
// ----------------------------------------------------------------------------
// Samples arrive on sample_ch and bundled results leave on result_ch, both
// valid/ready. Registers are written through cfg_write_en/cfg_index/cfg_data
// while the block is idle, a rule for the user that the block does not enforce,
// and apply to the next sample. The window is a row of cells that shifts once
// per accepted sample. The first WINDOW_DEPTH-1 samples only fill it and produce
// no result; after that each sample yields one result for the oldest entry.
// A sample that yields a result goes through shift, evaluate and the load of
// the output register. When the window extremum is needed as replacement, the
// window rotates once through the head cell to find it, between evaluate and load.
// The output register lets the block take the next sample while a result
// waits; a stalled receiver holds the block in its final step until the
// register frees. Reset empties the window, clears the side and the last
// kept value, and loads the register defaults.
// ----------------------------------------------------------------------------
module lookahead_threshold_bundler_top (
    input  logic                      clk,
    input  logic                      rst_n,
    lthb_sample_if.sink               sample_ch,
    lthb_result_if.source             result_ch,
    input  logic                      cfg_write_en,
    input  lthb_pkg::cfg_idx_t        cfg_index,
    input  logic [lthb_pkg::DATA_W-1:0] cfg_data
);
    import lthb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SWEEP,
        ST_EMIT
    } state_t;

    // Configuration registers.
    q88_t          threshold_reg;
    hang_t         hang_in_reg;
    hang_t         hang_out_reg;
    replace_mode_t replace_above_reg;
    replace_mode_t replace_below_reg;
    q88_t          set_above_reg;
    q88_t          set_below_reg;
    logic          binarize_reg;

    state_t state_reg,     state_next;
    count_t fill_reg,      fill_next;
    logic   first_reg,     first_next;
    logic   above_reg,     above_next;
    q88_t   last_kept_reg, last_kept_next;
    q88_t   res_reg,       res_next;
    idx_t   sweep_idx_reg, sweep_idx_next;
    logic   out_valid_reg, out_valid_next;
    q88_t   out_value_reg, out_value_next;
    logic   out_side_reg,  out_side_next;

    logic           in_accept;
    logic           rotate;
    q88_t           head;
    q88_t           tail_in;
    count_t         span;
    window_status_t status;
    logic           head_above;
    replace_mode_t  mode;

    assign in_accept = sample_ch.valid && sample_ch.ready;
    assign span      = clamp_hang(above_reg ? hang_out_reg : hang_in_reg);
    assign tail_in   = in_accept ? sample_ch.sample : head;
    assign head_above = (head > threshold_reg);

    lthb_chain u_chain (
        .clk       (clk),
        .shift_en  (in_accept || rotate),
        .tail_in   (tail_in),
        .threshold (threshold_reg),
        .span      (span),
        .head      (head),
        .status    (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg     <= '0;
            hang_in_reg       <= '0;
            hang_out_reg      <= '0;
            replace_above_reg <= MODE_PREVIOUS;
            replace_below_reg <= MODE_PREVIOUS;
            set_above_reg     <= '0;
            set_below_reg     <= '0;
            binarize_reg      <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_THRESHOLD:   threshold_reg     <= cfg_data;
                REG_HANG_IN:     hang_in_reg       <= cfg_data[HANG_W-1:0];
                REG_HANG_OUT:    hang_out_reg      <= cfg_data[HANG_W-1:0];
                REG_REPLACE_ABV: replace_above_reg <= replace_mode_t'(cfg_data[MODE_W-1:0]);
                REG_REPLACE_BLW: replace_below_reg <= replace_mode_t'(cfg_data[MODE_W-1:0]);
                REG_SET_ABOVE:   set_above_reg     <= cfg_data;
                REG_SET_BELOW:   set_below_reg     <= cfg_data;
                REG_BINARIZE:    binarize_reg      <= cfg_data[0];
                default:         binarize_reg      <= binarize_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        first_next     = first_reg;
        above_next     = above_reg;
        last_kept_next = last_kept_reg;
        res_next       = res_reg;
        sweep_idx_next = sweep_idx_reg;
        out_valid_next = out_valid_reg && !result_ch.ready;
        out_value_next = out_value_reg;
        out_side_next  = out_side_reg;
        rotate         = 1'b0;
        mode           = MODE_PREVIOUS;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (first_reg)
                    begin
                        above_next     = (sample_ch.sample > threshold_reg);
                        last_kept_next = sample_ch.sample;
                        first_next     = 1'b0;
                    end
                    if (fill_reg != DEPTH_CNT)
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    if (fill_next == DEPTH_CNT)
                    begin
                        state_next = ST_EVAL;
                    end
                end
            end

            ST_EVAL:
            begin
                state_next = ST_EMIT;
                if (status.all_above || status.none_above)
                begin
                    // A uniform lookahead decides the side; a zero span keeps it.
                    if (span != '0)
                    begin
                        above_next = status.all_above;
                    end
                    res_next       = head;
                    last_kept_next = head;
                end
                else if (above_reg == head_above)
                begin
                    res_next       = head;
                    last_kept_next = head;
                end
                else
                begin
                    mode = above_reg ? replace_below_reg : replace_above_reg;
                    case (mode)
                        MODE_EXTREMUM:
                        begin
                            res_next       = head;
                            sweep_idx_next = '0;
                            state_next     = ST_SWEEP;
                        end
                        MODE_PREVIOUS:  res_next = last_kept_reg;
                        MODE_THRESHOLD: res_next = threshold_reg;
                        default:        res_next = above_reg ? set_above_reg : set_below_reg;
                    endcase
                end
            end

            ST_SWEEP:
            begin
                // The window rotates a full turn, so it ends where it began.
                rotate = 1'b1;
                if (CNT_W'(sweep_idx_reg) < span)
                begin
                    if ((above_reg && (head > res_reg)) || (!above_reg && (head <= res_reg)))
                    begin
                        res_next = head;
                    end
                end
                sweep_idx_next = sweep_idx_reg + 1'b1;
                if (sweep_idx_reg == LAST_IDX)
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || result_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_side_next  = above_reg;
                    if (binarize_reg)
                        out_value_next = (res_reg <= threshold_reg) ? set_below_reg
                                                                    : set_above_reg;
                    else
                        out_value_next = res_reg;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            first_reg     <= 1'b1;
            above_reg     <= 1'b0;
            last_kept_reg <= '0;
            res_reg       <= '0;
            sweep_idx_reg <= '0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_side_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            first_reg     <= first_next;
            above_reg     <= above_next;
            last_kept_reg <= last_kept_next;
            res_reg       <= res_next;
            sweep_idx_reg <= sweep_idx_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            out_side_reg  <= out_side_next;
        end
    end

    assign sample_ch.ready      = (state_reg == ST_IDLE);
    assign result_ch.valid      = out_valid_reg;
    assign result_ch.out_value  = out_value_reg;
    assign result_ch.side_above = out_side_reg;

`ifndef SYNTHESIS
    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result appeared outside the emit step");

    a_full_window_evaluates: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (fill_reg == DEPTH_CNT || fill_reg == DEPTH_CNT - 1'b1))
            |=> (state_reg == ST_EVAL))
        else $error("sample into a full window was not evaluated");

    a_sweep_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (fill_reg == DEPTH_CNT && !first_reg))
        else $error("extremum sweep on a window that is not full");
`endif

endmodule

// ===== rtl/core/lthb_cell.sv =====
// ----------------------------------------------------------------------------
// lthb_cell
// One window entry: holds a sample, takes its neighbor's value on a shift
// and reports whether it lies above threshold inside the lookahead span.
// ----------------------------------------------------------------------------
module lthb_cell (
    input  logic            clk,
    input  logic            shift_en,
    input  lthb_pkg::q88_t  d_in,
    input  lthb_pkg::q88_t  threshold,
    input  lthb_pkg::count_t span,
    input  lthb_pkg::count_t cell_idx,
    output lthb_pkg::q88_t  q,
    output logic            in_span,
    output logic            above
);
    import lthb_pkg::*;

    q88_t value_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            value_reg <= d_in;
        end
    end

    assign q       = value_reg;
    assign in_span = (cell_idx < span);
    assign above   = in_span && (value_reg > threshold);

endmodule

// ===== rtl/core/lthb_chain.sv =====
// ----------------------------------------------------------------------------
// lthb_chain
// Row of window cells, oldest at the head. A shift moves every entry one
// place toward the head and loads the tail; feeding the head back rotates.
// ----------------------------------------------------------------------------
module lthb_chain (
    input  logic                    clk,
    input  logic                    shift_en,
    input  lthb_pkg::q88_t          tail_in,
    input  lthb_pkg::q88_t          threshold,
    input  lthb_pkg::count_t        span,
    output lthb_pkg::q88_t          head,
    output lthb_pkg::window_status_t status
);
    import lthb_pkg::*;

    q88_t                    q_vec [WINDOW_DEPTH];
    q88_t                    d_vec [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] span_vec;
    logic [WINDOW_DEPTH-1:0] above_vec;

    genvar i;
    generate
        for (i = 0; i < WINDOW_DEPTH; i++)
        begin : g_cell
            if (i == WINDOW_DEPTH - 1)
            begin : g_tail
                assign d_vec[i] = tail_in;
            end
            else
            begin : g_body
                assign d_vec[i] = q_vec[i+1];
            end

            lthb_cell u_cell (
                .clk       (clk),
                .shift_en  (shift_en),
                .d_in      (d_vec[i]),
                .threshold (threshold),
                .span      (span),
                .cell_idx  (CNT_W'(i)),
                .q         (q_vec[i]),
                .in_span   (span_vec[i]),
                .above     (above_vec[i])
            );
        end
    endgenerate

    assign head              = q_vec[0];
    assign status.all_above  = &(above_vec | ~span_vec);
    assign status.none_above = ~|above_vec;

endmodule
